// ----- rtl/tlv8fm_pkg.sv -----
package tlv8fm_pkg;

   localparam int BYTE_W          = 8;
   localparam int LEN_OUT_W       = 16;
   localparam int LENGTH_BITS_DEF = 16;
   localparam int FIFO_DEPTH      = 4;
   localparam logic [BYTE_W-1:0] FULL_FRAG = 8'd255;

   typedef enum logic [1:0] {
      PH_TYPE  = 2'd0,
      PH_LEN   = 2'd1,
      PH_VALUE = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    item_type;
      logic [BYTE_W-1:0]    value_byte;
      logic                 has_value;
      logic                 item_end;
      logic [LEN_OUT_W-1:0] total_length;
      logic                 truncated;
   } result_type;

   typedef struct packed {
      logic       a_valid;
      logic       b_valid;
      result_type a;
      result_type b;
   } push_type;

endpackage

// ----- rtl/tlv8fm_parser.sv -----
module tlv8fm_parser
   import tlv8fm_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic [BYTE_W-1:0] in_byte,
   input  logic              stream_end,
   output push_type          push
);

   phase_type               phase_ff, phase_in;
   logic [BYTE_W-1:0]       cur_type_ff, cur_type_in;
   logic [BYTE_W-1:0]       bytes_left_ff, bytes_left_in;
   logic                    frag_full_ff, frag_full_in;
   logic                    cont_open_ff, cont_open_in;
   logic [BYTE_W-1:0]       open_type_ff, open_type_in;
   logic [LENGTH_BITS-1:0]  merged_ff, merged_in;
   logic                    done;

   function automatic logic [LEN_OUT_W-1:0] to_out(input logic [LENGTH_BITS-1:0] len);
      logic [31:0] wide;
      wide = 32'(len);
      return wide[LEN_OUT_W-1:0];
   endfunction

   function automatic result_type mk_close(input logic [BYTE_W-1:0] typ,
                                           input logic [LENGTH_BITS-1:0] len,
                                           input logic trunc);
      result_type r;
      r.item_type    = typ;
      r.value_byte   = '0;
      r.has_value    = 1'b0;
      r.item_end     = 1'b1;
      r.total_length = to_out(len);
      r.truncated    = trunc;
      return r;
   endfunction

   always_comb begin
      phase_in      = phase_ff;
      cur_type_in   = cur_type_ff;
      bytes_left_in = bytes_left_ff;
      frag_full_in  = frag_full_ff;
      cont_open_in  = cont_open_ff;
      open_type_in  = open_type_ff;
      merged_in     = merged_ff;
      done          = 1'b0;
      push          = '0;
      unique case (phase_ff)
         PH_TYPE: begin
            if (cont_open_ff) begin
               if (in_byte != open_type_ff) begin
                  push.a_valid = 1'b1;
                  push.a       = mk_close(open_type_ff, merged_ff, 1'b0);
                  merged_in    = '0;
               end
               cont_open_in = 1'b0;
            end else begin
               merged_in = '0;
            end
            cur_type_in = in_byte;
            phase_in    = PH_LEN;
         end
         PH_LEN: begin
            bytes_left_in = in_byte;
            frag_full_in  = (in_byte == FULL_FRAG);
            if (in_byte == '0) begin
               push.a_valid = 1'b1;
               push.a       = mk_close(cur_type_ff, merged_ff, 1'b0);
               merged_in    = '0;
               phase_in     = PH_TYPE;
            end else begin
               phase_in = PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (merged_ff != '1) begin
               merged_in = merged_ff + 1'b1;
            end
            bytes_left_in = bytes_left_ff - 1'b1;
            done          = (bytes_left_in == '0);
            if (done && frag_full_ff) begin
               cont_open_in = 1'b1;
               open_type_in = cur_type_ff;
            end
            push.a_valid           = 1'b1;
            push.a.item_type       = cur_type_ff;
            push.a.value_byte      = in_byte;
            push.a.has_value       = 1'b1;
            push.a.item_end        = done && !frag_full_ff;
            push.a.total_length    = to_out(merged_in);
            push.a.truncated       = 1'b0;
            if (done) begin
               if (!frag_full_ff) begin
                  merged_in = '0;
               end
               phase_in = PH_TYPE;
            end
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase
      if (stream_end) begin
         if (phase_in != PH_TYPE) begin
            push.b_valid = 1'b1;
            push.b       = mk_close(cur_type_in, merged_in, 1'b1);
         end else if (cont_open_in) begin
            push.b_valid = 1'b1;
            push.b       = mk_close(open_type_in, merged_in, 1'b0);
         end
         phase_in      = PH_TYPE;
         cur_type_in   = '0;
         bytes_left_in = '0;
         frag_full_in  = 1'b0;
         cont_open_in  = 1'b0;
         open_type_in  = '0;
         merged_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_TYPE;
         cur_type_ff   <= '0;
         bytes_left_ff <= '0;
         frag_full_ff  <= 1'b0;
         cont_open_ff  <= 1'b0;
         open_type_ff  <= '0;
         merged_ff     <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         cur_type_ff   <= cur_type_in;
         bytes_left_ff <= bytes_left_in;
         frag_full_ff  <= frag_full_in;
         cont_open_ff  <= cont_open_in;
         open_type_ff  <= open_type_in;
         merged_ff     <= merged_in;
      end
   end

endmodule

// ----- rtl/tlv8fm_rsp_fifo.sv -----
module tlv8fm_rsp_fifo
   import tlv8fm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_en,
   input  push_type   push,
   output logic       room,
   output logic       head_valid,
   output result_type head,
   input  logic       pop_ready
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   result_type        mem [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        push_cnt;
   logic              pop;
   result_type        first;

   assign head_valid = (count_ff != '0);
   assign head       = mem[rd_ptr_ff];
   assign pop        = head_valid && pop_ready;
   assign room       = (count_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign first      = push.a_valid ? push.a : push.b;

   always_comb begin
      push_cnt = '0;
      if (push_en) begin
         push_cnt = 2'(push.a_valid) + 2'(push.b_valid);
      end
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push_cnt) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem[wr_ptr_ff] <= first;
      end
      if (push_cnt == 2'd2) begin
         mem[PTR_W'(wr_ptr_ff + 1'b1)] <= push.b;
      end
   end

endmodule

// ----- rtl/tlv8_fragment_merging_decoder_core.sv -----
// A byte accepted into the input register is parsed, and any results it yields are written to the result queue.
// Throughput: one byte per cycle while the result queue has room for two more results; a byte
// that closes the stream may add a second result to the four-entry result queue.
// Reset is synchronous and active high; it returns the parser to the type phase,
// clears all merge state and empties the result queue.
module tlv8_fragment_merging_decoder_core
   import tlv8fm_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // item_type[7:0], value_byte[15:8], total_length[31:16]
   output logic [1:0]  rsp_tuser,   // has_value[0], truncated[1]
   output logic        rsp_tlast
);

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff;
   logic              s1_last_ff;
   logic              room;
   logic              advance;
   logic              req_take;
   push_type          push;
   result_type        head;

   assign advance    = s1_valid_ff && room;
   assign req_tready = !s1_valid_ff || room;
   assign req_take   = req_tvalid && req_tready;
   assign s1_valid_in = req_take || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   tlv8fm_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_byte    (s1_byte_ff),
      .stream_end (s1_last_ff),
      .push       (push)
   );

   tlv8fm_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_en    (advance),
      .push       (push),
      .room       (room),
      .head_valid (rsp_tvalid),
      .head       (head),
      .pop_ready  (rsp_tready)
   );

   assign rsp_tdata = {head.total_length, head.value_byte, head.item_type};
   assign rsp_tuser = {head.truncated, head.has_value};
   assign rsp_tlast = head.item_end;

`ifndef SYNTHESIS
   a_second_only_at_end: assert property (@(posedge clock) disable iff (reset)
      advance && push.b_valid |-> s1_last_ff)
      else $error("second result pushed for a byte that does not end the stream");

   a_second_is_close: assert property (@(posedge clock) disable iff (reset)
      advance && push.b_valid |-> push.b.item_end && !push.b.has_value)
      else $error("stream end flush is not a close without value");

   a_stall_holds_byte: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_last_ff))
      else $error("input register changed while stalled");
`endif

endmodule
